// ===== sv/nmsm_pkg.sv =====
// Shared types, codes and constants of the navigation mode state machine.
`timescale 1ns / 1ps
`default_nettype none
package nmsm_pkg;

  // Navigation modes
  localparam logic [2:0] MODE_FORWARD   = 3'd0;
  localparam logic [2:0] MODE_CAUTIOUS  = 3'd1;
  localparam logic [2:0] MODE_AVOIDING  = 3'd2;
  localparam logic [2:0] MODE_ESCAPE    = 3'd3;
  localparam logic [2:0] MODE_EMERGENCY = 3'd4;
  localparam logic [2:0] MODE_BLOCKED   = 3'd5;

  // Danger levels
  localparam logic [2:0] DANGER_SAFE      = 3'd0;
  localparam logic [2:0] DANGER_CAUTION   = 3'd1;
  localparam logic [2:0] DANGER_AVOID     = 3'd2;
  localparam logic [2:0] DANGER_BLOCKED   = 3'd3;
  localparam logic [2:0] DANGER_EMERGENCY = 3'd4;
  localparam logic [2:0] DANGER_UNKNOWN   = 3'd5;

  // Move actions
  localparam logic [2:0] ACT_FORWARD     = 3'd0;
  localparam logic [2:0] ACT_CURVE_LEFT  = 3'd1;
  localparam logic [2:0] ACT_CURVE_RIGHT = 3'd2;
  localparam logic [2:0] ACT_BACKWARD    = 3'd3;
  localparam logic [2:0] ACT_STOP        = 3'd4;

  // Turn sides
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // Motion profiles
  localparam logic [1:0] PROF_NORMAL    = 2'd0;
  localparam logic [1:0] PROF_CAUTIOUS  = 2'd1;
  localparam logic [1:0] PROF_ESCAPE    = 2'd2;
  localparam logic [1:0] PROF_EMERGENCY = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_MIN_DWELL   = 3'd0;
  localparam logic [2:0] REG_AVOID_COOL  = 3'd1;
  localparam logic [2:0] REG_BLOCKED_LIM = 3'd2;
  localparam logic [2:0] REG_ENABLES     = 3'd3;
  localparam logic [2:0] REG_LOW_CONF    = 3'd4;
  localparam logic [2:0] REG_SPEED_TABLE = 3'd5;
  localparam logic [2:0] REG_AVOID_ANGLE = 3'd6;
  localparam logic [2:0] REG_ESC_ANGLE   = 3'd7;

  // Enable bits
  localparam int EN_OVERRIDE = 0;
  localparam int EN_ADAPT    = 1;
  localparam int EN_PERSIST  = 2;

  // Register reset values
  localparam logic [15:0] RST_MIN_DWELL   = 16'd500;
  localparam logic [15:0] RST_AVOID_COOL  = 16'd1000;
  localparam logic [7:0]  RST_BLOCKED_LIM = 8'd5;
  localparam logic [2:0]  RST_ENABLES     = 3'd7;
  localparam logic [15:0] RST_LOW_CONF    = 16'd9830;
  localparam logic [23:0] RST_SPEED_TABLE = 24'h408080;
  localparam logic [11:0] RST_AVOID_ANGLE = 12'd480;
  localparam logic [11:0] RST_ESC_ANGLE   = 12'd1440;

  localparam logic [7:0]  SPEED_MAX    = 8'd128;
  localparam logic [11:0] ANGLE_MAX    = 12'd2880;
  localparam logic [15:0] CONF_ONE     = 16'd32768;
  localparam logic [7:0]  RUN_MAX      = 8'd255;
  // floor(x / 10) = (x * DIV10_MULT) >> DIV10_SHIFT, exact for x below 2^18
  localparam logic [17:0] DIV10_MULT   = 18'd209716;
  localparam int          DIV10_SHIFT  = 21;

  typedef struct packed {
    logic [15:0] min_dwell_ms;
    logic [15:0] avoid_cooldown_ms;
    logic [7:0]  blocked_limit;
    logic [2:0]  mode_enables;
    logic [15:0] low_confidence_level;
    logic [23:0] speed_table;
    logic [11:0] avoid_angle;
    logic [11:0] escape_angle;
  } cfg_t;

  // Classified frame handed from the front to the back
  typedef struct packed {
    logic [2:0]  target;
    logic        override_hit;
    logic [15:0] confidence;
    logic [31:0] time_ms;
    logic        coin_bit;
  } cls_t;

  // Finished decision
  typedef struct packed {
    logic [2:0]         nav_mode;
    logic [2:0]         move_action;
    logic [1:0]         turn_side;
    logic [1:0]         motion_profile;
    logic [7:0]         speed_out;
    logic signed [12:0] turn_angle;
    logic               override_hit;
    logic               escape_active;
    logic               avoid_active;
    logic               persist_flag;
    logic [15:0]        confidence_out;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/nmsm_front.sv =====
// Front stage: accept a frame, map danger to a target mode and adapt confidence.
`timescale 1ns / 1ps
`default_nettype none
module nmsm_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire nmsm_pkg::cfg_t      cfg,
  input  wire logic                take,
  input  wire logic [2:0]          danger_level,
  input  wire logic                emergency_seen,
  input  wire logic signed [17:0]  raw_confidence,
  input  wire logic [31:0]         time_ms,
  input  wire logic                coin_bit,
  input  wire logic                q_full,
  output logic                     busy,
  output logic                     out_valid,
  output nmsm_pkg::cls_t           out_item
);

  logic           stage_valid;
  nmsm_pkg::cls_t stage_item;
  nmsm_pkg::cls_t cls;
  logic [15:0]    clamped;
  logic [17:0]    times7;
  logic [35:0]    prod;
  logic [2:0]     base_target;
  logic           ovr;

  // Clamp to 0..1.0 and, when adaptation is enabled, scale by 0.7 below the threshold
  always_comb begin
    if (raw_confidence[17]) begin
      clamped = '0;
    end else if (raw_confidence > $signed({2'b00, nmsm_pkg::CONF_ONE})) begin
      clamped = nmsm_pkg::CONF_ONE;
    end else begin
      clamped = raw_confidence[15:0];
    end
    times7 = {clamped, 2'b00} + {1'b0, clamped, 1'b0} + {2'b00, clamped};
    prod   = times7 * nmsm_pkg::DIV10_MULT;
  end

  always_comb begin
    unique case (danger_level)
      nmsm_pkg::DANGER_CAUTION:   base_target = nmsm_pkg::MODE_CAUTIOUS;
      nmsm_pkg::DANGER_AVOID:     base_target = nmsm_pkg::MODE_AVOIDING;
      nmsm_pkg::DANGER_BLOCKED:   base_target = nmsm_pkg::MODE_ESCAPE;
      nmsm_pkg::DANGER_EMERGENCY: base_target = nmsm_pkg::MODE_EMERGENCY;
      nmsm_pkg::DANGER_UNKNOWN:   base_target = nmsm_pkg::MODE_CAUTIOUS;
      default:                    base_target = nmsm_pkg::MODE_FORWARD;
    endcase
    ovr = cfg.mode_enables[nmsm_pkg::EN_OVERRIDE] &&
          (emergency_seen || danger_level == nmsm_pkg::DANGER_EMERGENCY);

    cls.target       = ovr ? nmsm_pkg::MODE_EMERGENCY : base_target;
    cls.override_hit = ovr;
    if (cfg.mode_enables[nmsm_pkg::EN_ADAPT] && clamped < cfg.low_confidence_level) begin
      cls.confidence = {1'b0, prod[35:nmsm_pkg::DIV10_SHIFT]};
    end else begin
      cls.confidence = clamped;
    end
    cls.time_ms  = time_ms;
    cls.coin_bit = coin_bit;
  end

  // Hold the staged frame while the queue is full
  assign busy      = stage_valid && q_full;
  assign out_valid = stage_valid;
  assign out_item  = stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (!q_full) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_item <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== sv/nmsm_cmdq.sv =====
// Four-entry queue of classified frames between front and back.
`timescale 1ns / 1ps
`default_nettype none
module nmsm_cmdq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  input  wire nmsm_pkg::cls_t wr_item,
  output logic                q_full,
  input  wire logic           rd_take,
  output logic                rd_valid,
  output nmsm_pkg::cls_t      rd_item
);

  localparam int Depth = 4;

  nmsm_pkg::cls_t          mem [Depth];
  logic [1:0]              wp;
  logic [1:0]              rp;
  logic [2:0]              count;
  logic                    wr;
  logic                    rd;

  assign q_full   = (count == 3'(Depth));
  assign rd_valid = (count != 3'd0);
  assign rd_item  = mem[rp];
  assign wr       = wr_valid && !q_full;
  assign rd       = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 2'd1;
      end
      if (rd) begin
        rp <= rp + 2'd1;
      end
      if (wr && !rd) begin
        count <= count + 3'd1;
      end else if (rd && !wr) begin
        count <= count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/nmsm_back.sv =====
// Back stage: mode state, change gating, decision build and result buffer.
`timescale 1ns / 1ps
`default_nettype none
module nmsm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire nmsm_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  input  wire nmsm_pkg::cls_t in_item,
  output logic                in_take,
  input  wire logic           res_pop,
  output logic                res_empty,
  output nmsm_pkg::res_t      res_item
);

  logic [2:0]     current_mode;
  logic [31:0]    mode_entry_time;
  logic [31:0]    cooldown_until;
  logic [1:0]     last_turn;
  logic [7:0]     escape_run;

  nmsm_pkg::res_t rbuf [2];
  logic           wp;
  logic           rp;
  logic [1:0]     rcount;

  logic [2:0]     escalated;
  logic [31:0]    elapsed;
  logic           may_change;
  logic [2:0]     tgt;
  logic [1:0]     side;
  logic [11:0]    ang;
  logic [7:0]     spd_normal;
  logic [7:0]     spd_cautious;
  logic [7:0]     spd_escape;
  nmsm_pkg::res_t res;
  logic           rd;

  function automatic logic [7:0] sat_speed(input logic [7:0] v);
    sat_speed = (v > nmsm_pkg::SPEED_MAX) ? nmsm_pkg::SPEED_MAX : v;
  endfunction

  function automatic logic [11:0] sat_angle(input logic [11:0] v);
    sat_angle = (v > nmsm_pkg::ANGLE_MAX) ? nmsm_pkg::ANGLE_MAX : v;
  endfunction

  assign in_take = in_valid && (rcount != 2'd2);

  always_comb begin
    escalated = (escape_run >= cfg.blocked_limit) ? nmsm_pkg::MODE_BLOCKED : in_item.target;
    elapsed   = in_item.time_ms - mode_entry_time;
    if (escalated == current_mode || escalated == nmsm_pkg::MODE_EMERGENCY) begin
      may_change = 1'b1;
    end else if (in_item.time_ms < cooldown_until) begin
      may_change = 1'b0;
    end else begin
      may_change = (elapsed >= {16'd0, cfg.min_dwell_ms});
    end
    tgt = may_change ? escalated : current_mode;

    if (tgt == nmsm_pkg::MODE_AVOIDING) begin
      side = (last_turn == nmsm_pkg::SIDE_LEFT) ? nmsm_pkg::SIDE_RIGHT : nmsm_pkg::SIDE_LEFT;
    end else if (tgt == nmsm_pkg::MODE_ESCAPE) begin
      side = in_item.coin_bit ? nmsm_pkg::SIDE_RIGHT : nmsm_pkg::SIDE_LEFT;
    end else begin
      side = nmsm_pkg::SIDE_NONE;
    end

    spd_normal   = sat_speed(cfg.speed_table[7:0]);
    spd_cautious = sat_speed(cfg.speed_table[15:8]);
    spd_escape   = sat_speed(cfg.speed_table[23:16]);

    ang = '0;
    res = '0;
    unique case (tgt)
      nmsm_pkg::MODE_FORWARD: begin
        res.move_action    = nmsm_pkg::ACT_FORWARD;
        res.motion_profile = nmsm_pkg::PROF_NORMAL;
        res.speed_out      = spd_normal;
      end
      nmsm_pkg::MODE_CAUTIOUS: begin
        res.move_action    = nmsm_pkg::ACT_FORWARD;
        res.motion_profile = nmsm_pkg::PROF_CAUTIOUS;
        res.speed_out      = spd_cautious;
      end
      nmsm_pkg::MODE_AVOIDING: begin
        res.move_action    = (side == nmsm_pkg::SIDE_LEFT) ? nmsm_pkg::ACT_CURVE_LEFT
                                                            : nmsm_pkg::ACT_CURVE_RIGHT;
        res.motion_profile = nmsm_pkg::PROF_CAUTIOUS;
        res.speed_out      = spd_cautious;
        ang                = sat_angle(cfg.avoid_angle);
      end
      nmsm_pkg::MODE_ESCAPE: begin
        res.move_action    = nmsm_pkg::ACT_BACKWARD;
        res.motion_profile = nmsm_pkg::PROF_ESCAPE;
        res.speed_out      = spd_escape;
        ang                = sat_angle(cfg.escape_angle);
      end
      nmsm_pkg::MODE_EMERGENCY: begin
        res.move_action    = nmsm_pkg::ACT_STOP;
        res.motion_profile = nmsm_pkg::PROF_EMERGENCY;
        res.speed_out      = '0;
      end
      default: begin
        res.move_action    = nmsm_pkg::ACT_STOP;
        res.motion_profile = nmsm_pkg::PROF_NORMAL;
        res.speed_out      = '0;
      end
    endcase

    res.nav_mode       = tgt;
    res.turn_side      = side;
    res.turn_angle     = (side == nmsm_pkg::SIDE_LEFT) ? -$signed({1'b0, ang})
                                                       : $signed({1'b0, ang});
    res.override_hit   = in_item.override_hit;
    res.escape_active  = (tgt == nmsm_pkg::MODE_ESCAPE);
    res.avoid_active   = (tgt == nmsm_pkg::MODE_AVOIDING);
    res.persist_flag   = cfg.mode_enables[nmsm_pkg::EN_PERSIST] &&
                         (tgt >= nmsm_pkg::MODE_AVOIDING);
    res.confidence_out = in_item.confidence;
  end

  // Mode state advances once per frame taken
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode    <= nmsm_pkg::MODE_FORWARD;
      mode_entry_time <= '0;
      cooldown_until  <= '0;
      last_turn       <= nmsm_pkg::SIDE_NONE;
      escape_run      <= '0;
    end else if (in_take) begin
      if (tgt != current_mode) begin
        current_mode    <= tgt;
        mode_entry_time <= in_item.time_ms;
        if (tgt == nmsm_pkg::MODE_AVOIDING) begin
          cooldown_until <= in_item.time_ms + {16'd0, cfg.avoid_cooldown_ms};
        end
      end
      if (side != nmsm_pkg::SIDE_NONE) begin
        last_turn <= side;
      end
      if (tgt == nmsm_pkg::MODE_ESCAPE) begin
        if (escape_run != nmsm_pkg::RUN_MAX) begin
          escape_run <= escape_run + 8'd1;
        end
      end else begin
        escape_run <= '0;
      end
    end
  end

  // Two-entry result buffer
  assign res_empty = (rcount == 2'd0);
  assign res_item  = rbuf[rp];
  assign rd        = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= 1'b0;
      rp     <= 1'b0;
      rcount <= '0;
    end else begin
      if (in_take) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      if (in_take && !rd) begin
        rcount <= rcount + 2'd1;
      end else if (rd && !in_take) begin
        rcount <= rcount - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rbuf[wp] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sv/navigation_mode_state_machine_core.sv =====
// Top level of the navigation mode state machine: config registers, front, queue, back.
//
// Usage
//   Input channel: one obstacle report (a beat) per frame. A beat is taken at a
//   rising edge with push high and full low.
//   Result channel: one navigation decision per input beat, in order. The
//   oldest decision sits on the result ports while empty is low and is taken
//   at a rising edge with pop high and empty low.
//   Config port: cfg_we writes cfg_data into register cfg_index at the edge;
//   write only while no frame is in flight.
// Path: a taken beat loads the front stage register at the taking edge, then the
//   four-entry classified-frame queue, then its decision enters the back decision
//   buffer, each step waiting while the next one is full.
// Throughput: one beat per cycle each way while pop stays high; the back stage
//   keeps one decision per cycle since its mode state feeds back through one register.
// Stall: when pop stays low the two-entry result buffer fills, the back stage
//   holds, the queue fills, and full rises after up to seven beats are held.
// Reset: rst (synchronous, active high) returns the mode state to forward,
//   clears timers and counters, empties all queues and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module navigation_mode_state_machine_core (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  // input queue side
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         danger_level,
  input  wire logic               emergency_seen,
  input  wire logic signed [17:0] raw_confidence,
  input  wire logic [31:0]        time_ms,
  input  wire logic               coin_bit,
  // result queue side
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              nav_mode,
  output logic [2:0]              move_action,
  output logic [1:0]              turn_side,
  output logic [1:0]              motion_profile,
  output logic [7:0]              speed_out,
  output logic signed [12:0]      turn_angle,
  output logic                    override_hit,
  output logic                    escape_active,
  output logic                    avoid_active,
  output logic                    persist_flag,
  output logic [15:0]             confidence_out
);

  nmsm_pkg::cfg_t cfg;
  logic           take;
  logic           front_busy;
  logic           front_valid;
  nmsm_pkg::cls_t front_item;
  logic           q_full;
  logic           q_valid;
  nmsm_pkg::cls_t q_item;
  logic           back_take;
  nmsm_pkg::res_t res;

  // Configuration registers; out-of-range bits of cfg_data are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_dwell_ms         <= nmsm_pkg::RST_MIN_DWELL;
      cfg.avoid_cooldown_ms    <= nmsm_pkg::RST_AVOID_COOL;
      cfg.blocked_limit        <= nmsm_pkg::RST_BLOCKED_LIM;
      cfg.mode_enables         <= nmsm_pkg::RST_ENABLES;
      cfg.low_confidence_level <= nmsm_pkg::RST_LOW_CONF;
      cfg.speed_table          <= nmsm_pkg::RST_SPEED_TABLE;
      cfg.avoid_angle          <= nmsm_pkg::RST_AVOID_ANGLE;
      cfg.escape_angle         <= nmsm_pkg::RST_ESC_ANGLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nmsm_pkg::REG_MIN_DWELL:   cfg.min_dwell_ms         <= cfg_data[15:0];
        nmsm_pkg::REG_AVOID_COOL:  cfg.avoid_cooldown_ms    <= cfg_data[15:0];
        nmsm_pkg::REG_BLOCKED_LIM: cfg.blocked_limit        <= cfg_data[7:0];
        nmsm_pkg::REG_ENABLES:     cfg.mode_enables         <= cfg_data[2:0];
        nmsm_pkg::REG_LOW_CONF:    cfg.low_confidence_level <= cfg_data[15:0];
        nmsm_pkg::REG_SPEED_TABLE: cfg.speed_table          <= cfg_data;
        nmsm_pkg::REG_AVOID_ANGLE: cfg.avoid_angle          <= cfg_data[11:0];
        nmsm_pkg::REG_ESC_ANGLE:   cfg.escape_angle         <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  // Front takes a beat unless its stage is stuck behind a full queue
  assign full = front_busy;
  assign take = push && !front_busy;

  nmsm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .take           (take),
    .danger_level   (danger_level),
    .emergency_seen (emergency_seen),
    .raw_confidence (raw_confidence),
    .time_ms        (time_ms),
    .coin_bit       (coin_bit),
    .q_full         (q_full),
    .busy           (front_busy),
    .out_valid      (front_valid),
    .out_item       (front_item)
  );

  nmsm_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_item  (front_item),
    .q_full   (q_full),
    .rd_take  (back_take),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  nmsm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .in_take   (back_take),
    .res_pop   (pop),
    .res_empty (empty),
    .res_item  (res)
  );

  assign nav_mode       = res.nav_mode;
  assign move_action    = res.move_action;
  assign turn_side      = res.turn_side;
  assign motion_profile = res.motion_profile;
  assign speed_out      = res.speed_out;
  assign turn_angle     = res.turn_angle;
  assign override_hit   = res.override_hit;
  assign escape_active  = res.escape_active;
  assign avoid_active   = res.avoid_active;
  assign persist_flag   = res.persist_flag;
  assign confidence_out = res.confidence_out;

  // Stop modes never command motion
  a_stop_no_speed: assert property (@(posedge clk) disable iff (rst)
    (!empty && (nav_mode == nmsm_pkg::MODE_EMERGENCY || nav_mode == nmsm_pkg::MODE_BLOCKED))
      |-> (speed_out == 8'd0))
    else $error("stop mode with nonzero speed");

  // No turn side means no turn angle
  a_no_side_no_angle: assert property (@(posedge clk) disable iff (rst)
    (!empty && turn_side == nmsm_pkg::SIDE_NONE) |-> (turn_angle == 13'sd0))
    else $error("turn angle without a turn side");

  // Persistence only flags the avoidance family of modes
  a_persist_mode: assert property (@(posedge clk) disable iff (rst)
    (!empty && persist_flag) |-> (nav_mode >= nmsm_pkg::MODE_AVOIDING))
    else $error("persist flag on a forward or cautious mode");

endmodule
`default_nettype wire
